FILE: design/mqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mqs_pkg;

  localparam int NumTasks  = 64;
  localparam int TaskW     = 6;
  localparam int NumLevels = 8;
  localparam int LevelW    = 3;
  localparam int TimeW     = 32;
  localparam int QuantW    = 31;
  localparam int NowW      = 31;
  localparam int CmdW      = 3;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 31;

  localparam logic [CmdW-1:0] CMD_ADD_TAIL    = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD_HEAD    = 3'd1;
  localparam logic [CmdW-1:0] CMD_SET_STATUS  = 3'd2;
  localparam logic [CmdW-1:0] CMD_YIELD       = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLOCK_YIELD = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_QUANTUM      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXEMPT_LEVEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOWEST_LEVEL = 2'd2;

  localparam logic [QuantW-1:0] QUANTUM_RESET = 31'd100;
  localparam logic [LevelW-1:0] EXEMPT_RESET  = 3'd1;
  localparam logic [LevelW-1:0] LOWEST_RESET  = 3'd0;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  budget;
  } attr_t;

endpackage

`default_nettype wire

FILE: design/mqs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mqs_req_if;
  logic                        valid;
  logic                        ready;
  logic [mqs_pkg::CmdW-1:0]    cmd;
  logic [mqs_pkg::TaskW-1:0]   task_id;
  logic [mqs_pkg::LevelW-1:0]  priority_req;
  logic                        runnable;
  logic                        keep_budget;
  logic signed [mqs_pkg::TimeW-1:0] budget;
  logic [mqs_pkg::NowW-1:0]    now;

  modport source (output valid, cmd, task_id, priority_req, runnable, keep_budget, budget, now,
                  input ready);
  modport sink (input valid, cmd, task_id, priority_req, runnable, keep_budget, budget, now,
                output ready);
endinterface

`default_nettype wire

FILE: design/mqs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mqs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             dispatched;
  logic [mqs_pkg::TaskW-1:0]        run_task;
  logic signed [mqs_pkg::TimeW-1:0] deadline;
  logic                             idle;

  modport source (output valid, dispatched, run_task, deadline, idle, input ready);
  modport sink (input valid, dispatched, run_task, deadline, idle, output ready);
endinterface

`default_nettype wire

FILE: design/multilevel_quantum_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Multilevel quantum scheduler: one linked FIFO of tasks per priority level, with the
// links and the per-task level and budget held in RAMs with a registered read port.
// One command is worked at a time. An add goes from acceptance through read, unlink
// and link to the result state; a set status goes straight to the result state. A
// yield first requeues the running task by read, unlink and link (twice for a clock
// yield, not at all when no task runs), then steps down the levels past empty ones
// and pops queue heads until a runnable task is found or the lowest level is reached,
// then hands over the result; each pop is a RAM read followed by the unlink write-back.
// A result that rsp does not take holds the unit until the previous beat is gone. The
// next command is taken while the previous result beat still waits on rsp.
module multilevel_quantum_scheduler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mqs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [mqs_pkg::CfgDataW-1:0]  cfg_data,
  mqs_req_if.sink                            req,
  mqs_rsp_if.source                          rsp
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UNL  = 3'd2;
  localparam logic [2:0] ST_LNK  = 3'd3;
  localparam logic [2:0] ST_DISP = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] PH_ADD = 2'd0;
  localparam logic [1:0] PH_CY  = 2'd1;
  localparam logic [1:0] PH_RQ  = 2'd2;
  localparam logic [1:0] PH_DSP = 2'd3;

  localparam int TW = mqs_pkg::TaskW;
  localparam int LW = mqs_pkg::LevelW;
  localparam int MW = mqs_pkg::TimeW;

  logic [2:0] state;
  logic [1:0] phase;

  logic [mqs_pkg::QuantW-1:0] quantum;
  logic [LW-1:0] exempt_level;
  logic [LW-1:0] lowest_level;

  logic [TW-1:0] next_mem [mqs_pkg::NumTasks];
  logic [TW-1:0] prev_mem [mqs_pkg::NumTasks];
  mqs_pkg::attr_t attr_mem [mqs_pkg::NumTasks];
  logic [TW-1:0] next_q;
  logic [TW-1:0] prev_q;
  mqs_pkg::attr_t attr_q;
  logic attr_ok_q;

  logic [mqs_pkg::NumTasks-1:0] attr_ok;
  logic [mqs_pkg::NumTasks-1:0] queued;
  logic [mqs_pkg::NumTasks-1:0] task_runnable;
  logic [TW-1:0] level_head [mqs_pkg::NumLevels];
  logic [TW-1:0] level_tail [mqs_pkg::NumLevels];
  logic [mqs_pkg::NumLevels-1:0] level_nonempty;

  logic [TW-1:0] cur_task;
  logic          cur_valid;
  logic [TW-1:0] u;
  logic [LW-1:0] dl;
  logic [LW-1:0] lnk_lvl;
  logic          lnk_head;
  logic [MW-1:0] lnk_bud;

  logic [mqs_pkg::CmdW-1:0] cmd_r;
  logic [LW-1:0]            pr_r;
  logic                     keep_r;
  logic [MW-1:0]            b_r;
  logic [mqs_pkg::NowW-1:0] now_r;

  logic          res_disp;
  logic [TW-1:0] res_task;
  logic [MW-1:0] res_dl;
  logic          res_idle;

  logic          nx_we, pv_we, at_we;
  logic [TW-1:0] nx_addr, nx_data, pv_addr, pv_data;
  mqs_pkg::attr_t at_data;

  logic [LW-1:0] ulvl;
  logic [MW-1:0] bud;
  logic [MW-1:0] dbud;
  logic [MW-1:0] ddl;
  logic [MW-1:0] left;
  logic          expired;

  assign ulvl    = attr_ok_q ? attr_q.level : '0;
  assign bud     = attr_ok_q ? attr_q.budget : '0;
  assign dbud    = (bud == '0 && ulvl != exempt_level) ? {1'b0, quantum} : bud;
  assign ddl     = dbud + {1'b0, now_r};
  assign left    = bud - {1'b0, now_r};
  assign expired = (left == '0) || left[MW-1];

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    nx_we   = 1'b0;
    pv_we   = 1'b0;
    at_we   = 1'b0;
    nx_addr = u;
    nx_data = u;
    pv_addr = u;
    pv_data = u;
    at_data = '{level: lnk_lvl, budget: lnk_bud};
    unique case (state)
      ST_UNL: begin
        if (queued[u] && !(level_head[ulvl] == u)) begin
          if (level_tail[ulvl] == u) begin
            nx_we   = 1'b1;
            nx_addr = prev_q;
            nx_data = prev_q;
          end else begin
            nx_we   = 1'b1;
            nx_addr = prev_q;
            nx_data = next_q;
            pv_we   = 1'b1;
            pv_addr = next_q;
            pv_data = prev_q;
          end
        end
        if (phase == PH_DSP && task_runnable[u]) begin
          at_we   = 1'b1;
          at_data = '{level: ulvl, budget: ddl};
        end
      end
      ST_LNK: begin
        if (level_nonempty[lnk_lvl]) begin
          if (lnk_head) begin
            nx_we   = 1'b1;
            nx_data = level_head[lnk_lvl];
            pv_we   = 1'b1;
            pv_addr = level_head[lnk_lvl];
          end else begin
            pv_we   = 1'b1;
            pv_data = level_tail[lnk_lvl];
            nx_we   = 1'b1;
            nx_addr = level_tail[lnk_lvl];
          end
        end
        at_we = (phase != PH_CY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_addr] <= nx_data;
    if (pv_we) prev_mem[pv_addr] <= pv_data;
    if (at_we) attr_mem[u] <= at_data;
    next_q <= next_mem[u];
    prev_q <= prev_mem[u];
    attr_q <= attr_mem[u];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_ADD;
      quantum        <= mqs_pkg::QUANTUM_RESET;
      exempt_level   <= mqs_pkg::EXEMPT_RESET;
      lowest_level   <= mqs_pkg::LOWEST_RESET;
      attr_ok        <= '0;
      attr_ok_q      <= 1'b0;
      queued         <= '0;
      task_runnable  <= '0;
      level_nonempty <= '0;
      cur_task       <= '0;
      cur_valid      <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      attr_ok_q <= attr_ok[u];
      if (at_we) attr_ok[u] <= 1'b1;
      // A beat taken while the next result is handed over is replaced in ST_DONE.
      if (rsp.valid && rsp.ready && state != ST_DONE) rsp.valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          mqs_pkg::CFG_QUANTUM:      quantum <= cfg_data;
          mqs_pkg::CFG_EXEMPT_LEVEL: exempt_level <= cfg_data[LW-1:0];
          mqs_pkg::CFG_LOWEST_LEVEL: lowest_level <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_r    <= req.cmd;
            pr_r     <= req.priority_req;
            keep_r   <= req.keep_budget;
            b_r      <= req.budget;
            now_r    <= req.now;
            res_disp <= 1'b0;
            res_task <= '0;
            res_dl   <= '0;
            res_idle <= 1'b0;
            case (req.cmd) inside
              mqs_pkg::CMD_ADD_TAIL, mqs_pkg::CMD_ADD_HEAD: begin
                u     <= req.task_id;
                phase <= PH_ADD;
                state <= ST_RD;
              end
              mqs_pkg::CMD_SET_STATUS: begin
                task_runnable[req.task_id] <= req.runnable;
                state                      <= ST_DONE;
              end
              mqs_pkg::CMD_YIELD, mqs_pkg::CMD_CLOCK_YIELD: begin
                if (cur_valid) begin
                  u     <= cur_task;
                  phase <= (req.cmd == mqs_pkg::CMD_CLOCK_YIELD) ? PH_CY : PH_RQ;
                  state <= ST_RD;
                end else begin
                  phase <= PH_DSP;
                  dl    <= LW'(mqs_pkg::NumLevels - 1);
                  state <= ST_DISP;
                end
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_RD: state <= ST_UNL;
        ST_UNL: begin
          if (queued[u]) begin
            queued[u] <= 1'b0;
            if (level_head[ulvl] == u && level_tail[ulvl] == u) begin
              level_nonempty[ulvl] <= 1'b0;
            end else if (level_head[ulvl] == u) begin
              level_head[ulvl] <= next_q;
            end else if (level_tail[ulvl] == u) begin
              level_tail[ulvl] <= prev_q;
            end
          end
          case (phase)
            PH_ADD: begin
              lnk_lvl  <= pr_r;
              lnk_head <= (cmd_r == mqs_pkg::CMD_ADD_HEAD);
              lnk_bud  <= keep_r ? bud : b_r;
              state    <= ST_LNK;
            end
            PH_CY: begin
              lnk_lvl  <= ulvl;
              lnk_head <= 1'b1;
              state    <= ST_LNK;
            end
            PH_RQ: begin
              lnk_lvl <= ulvl;
              if (expired && ulvl != exempt_level) begin
                lnk_head <= 1'b0;
                lnk_bud  <= '0;
              end else begin
                lnk_head <= queued[u];
                lnk_bud  <= left;
              end
              state <= ST_LNK;
            end
            default: begin
              if (task_runnable[u]) begin
                cur_task  <= u;
                cur_valid <= 1'b1;
                res_disp  <= 1'b1;
                res_task  <= u;
                res_dl    <= ddl;
                state     <= ST_DONE;
              end else begin
                state <= ST_DISP;
              end
            end
          endcase
        end
        ST_LNK: begin
          queued[u] <= 1'b1;
          if (!level_nonempty[lnk_lvl]) begin
            level_head[lnk_lvl]     <= u;
            level_tail[lnk_lvl]     <= u;
            level_nonempty[lnk_lvl] <= 1'b1;
          end else if (lnk_head) begin
            level_head[lnk_lvl] <= u;
          end else begin
            level_tail[lnk_lvl] <= u;
          end
          case (phase)
            PH_ADD: state <= ST_DONE;
            PH_CY: begin
              phase <= PH_RQ;
              state <= ST_RD;
            end
            default: begin
              phase <= PH_DSP;
              dl    <= LW'(mqs_pkg::NumLevels - 1);
              state <= ST_DISP;
            end
          endcase
        end
        ST_DISP: begin
          if (level_nonempty[dl]) begin
            u     <= level_head[dl];
            state <= ST_RD;
          end else if (dl == lowest_level) begin
            cur_valid <= 1'b0;
            res_idle  <= 1'b1;
            state     <= ST_DONE;
          end else begin
            dl <= dl - 1'b1;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.dispatched <= res_disp;
            rsp.run_task   <= res_task;
            rsp.deadline   <= res_dl;
            rsp.idle       <= res_idle;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("accepted command did not start work");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !(res_disp && res_idle))
    else $error("result both dispatched and idle");

  a_dispatch_sets_current: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_disp) |-> (cur_valid && cur_task == res_task))
    else $error("dispatched task is not the running task");

  a_idle_clears_current: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_idle) |-> !cur_valid)
    else $error("idle result with a running task");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_multilevel_quantum_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_multilevel_quantum_scheduler_unit;

  typedef struct {
    logic [mqs_pkg::CmdW-1:0]   cmd;
    logic [mqs_pkg::TaskW-1:0]  task_id;
    logic [mqs_pkg::LevelW-1:0] prio;
    logic                       runnable;
    logic                       keep;
    logic [mqs_pkg::TimeW-1:0]  budget;
    logic [mqs_pkg::NowW-1:0]   now;
  } sched_cmd_t;

  typedef struct {
    logic                      dispatched;
    logic [mqs_pkg::TaskW-1:0] run_task;
    logic [mqs_pkg::TimeW-1:0] deadline;
    logic                      idle;
  } sched_pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mqs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [mqs_pkg::CfgDataW-1:0] cfg_data = '0;

  mqs_req_if req_bus ();
  mqs_rsp_if rsp_bus ();

  multilevel_quantum_scheduler_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_bus), .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  sched_cmd_t  cmd_backlog[$];
  sched_pick_t pick_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit req_took = 1'b0;
  int quiet_cycles = 0;
  logic [mqs_pkg::NowW-1:0] clock_now = '0;

  // Scheduler shadow state.
  logic [mqs_pkg::TaskW-1:0]  nxt_l[mqs_pkg::NumTasks];
  logic [mqs_pkg::TaskW-1:0]  prv_l[mqs_pkg::NumTasks];
  logic [mqs_pkg::LevelW-1:0] lvl_of[mqs_pkg::NumTasks];
  logic [mqs_pkg::TimeW-1:0]  bud[mqs_pkg::NumTasks];
  bit                         run_b[mqs_pkg::NumTasks];
  bit                         queued_b[mqs_pkg::NumTasks];
  logic [mqs_pkg::TaskW-1:0]  head_of[mqs_pkg::NumLevels];
  logic [mqs_pkg::TaskW-1:0]  tail_of[mqs_pkg::NumLevels];
  bit                         filled[mqs_pkg::NumLevels];
  logic [mqs_pkg::TaskW-1:0]  cur_t;
  bit                         cur_v;
  logic [mqs_pkg::QuantW-1:0] quantum_r;
  logic [mqs_pkg::LevelW-1:0] exempt_r;
  logic [mqs_pkg::LevelW-1:0] lowest_r;

  function automatic void shadow_reset();
    for (int i = 0; i < mqs_pkg::NumTasks; i++) begin
      nxt_l[i] = '0; prv_l[i] = '0; lvl_of[i] = '0; bud[i] = '0;
      run_b[i] = 0; queued_b[i] = 0;
    end
    for (int i = 0; i < mqs_pkg::NumLevels; i++) begin
      head_of[i] = '0; tail_of[i] = '0; filled[i] = 0;
    end
    cur_t = '0; cur_v = 0;
    quantum_r = mqs_pkg::QUANTUM_RESET;
    exempt_r = mqs_pkg::EXEMPT_RESET;
    lowest_r = mqs_pkg::LOWEST_RESET;
  endfunction

  function automatic void unlink(logic [mqs_pkg::TaskW-1:0] t);
    logic [mqs_pkg::LevelW-1:0] lv;
    logic [mqs_pkg::TaskW-1:0] nx, pv;
    if (!queued_b[t]) return;
    lv = lvl_of[t];
    nx = nxt_l[t];
    pv = prv_l[t];
    if (head_of[lv] == t && tail_of[lv] == t) begin
      filled[lv] = 0;
    end else if (head_of[lv] == t) begin
      head_of[lv] = nx;
    end else if (tail_of[lv] == t) begin
      tail_of[lv] = pv;
      nxt_l[pv] = pv;
    end else begin
      nxt_l[pv] = nx;
      prv_l[nx] = pv;
    end
    queued_b[t] = 0;
  endfunction

  function automatic void link(logic [mqs_pkg::TaskW-1:0] t, bit at_head);
    logic [mqs_pkg::LevelW-1:0] lv;
    lv = lvl_of[t];
    unlink(t);
    if (!filled[lv]) begin
      head_of[lv] = t; tail_of[lv] = t; filled[lv] = 1;
    end else if (at_head) begin
      nxt_l[t] = head_of[lv];
      prv_l[head_of[lv]] = t;
      head_of[lv] = t;
    end else begin
      prv_l[t] = tail_of[lv];
      nxt_l[tail_of[lv]] = t;
      tail_of[lv] = t;
    end
    queued_b[t] = 1;
  endfunction

  function automatic sched_pick_t schedule(sched_cmd_t c);
    sched_pick_t r;
    logic [mqs_pkg::TimeW-1:0] left, now32;
    logic [mqs_pkg::TaskW-1:0] t;
    bit expired;
    r = '{1'b0, '0, '0, 1'b0};
    now32 = {1'b0, c.now};
    case (c.cmd) inside
      mqs_pkg::CMD_ADD_TAIL, mqs_pkg::CMD_ADD_HEAD: begin
        unlink(c.task_id);
        lvl_of[c.task_id] = c.prio;
        link(c.task_id, c.cmd == mqs_pkg::CMD_ADD_HEAD);
        if (!c.keep) bud[c.task_id] = c.budget;
      end
      mqs_pkg::CMD_SET_STATUS: run_b[c.task_id] = c.runnable;
      mqs_pkg::CMD_YIELD, mqs_pkg::CMD_CLOCK_YIELD: begin
        if (cur_v) begin
          if (c.cmd == mqs_pkg::CMD_CLOCK_YIELD) link(cur_t, 1'b1);
          left = bud[cur_t] - now32;
          expired = (left == 0) || left[mqs_pkg::TimeW-1];
          if (expired && lvl_of[cur_t] != exempt_r) begin
            link(cur_t, 1'b0);
            bud[cur_t] = '0;
          end else begin
            link(cur_t, queued_b[cur_t]);
            bud[cur_t] = left;
          end
        end
        cur_v = 0;
        for (int lv = mqs_pkg::NumLevels - 1; lv >= int'(lowest_r) && !cur_v; lv--) begin
          while (filled[lv] && !cur_v) begin
            t = head_of[lv];
            unlink(t);
            if (run_b[t]) begin
              if (bud[t] == 0 && lvl_of[t] != exempt_r) bud[t] = {1'b0, quantum_r};
              bud[t] = bud[t] + now32;
              cur_t = t;
              cur_v = 1;
              r.dispatched = 1'b1;
              r.run_task = t;
              r.deadline = bud[t];
            end
          end
        end
        if (!cur_v) r.idle = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sched_cmd_t mk(logic [mqs_pkg::CmdW-1:0] cmd, int t, int p, bit rn,
                                    bit kp, logic [mqs_pkg::TimeW-1:0] b,
                                    logic [mqs_pkg::NowW-1:0] n);
    sched_cmd_t c;
    c.cmd = cmd; c.task_id = mqs_pkg::TaskW'(t); c.prio = mqs_pkg::LevelW'(p);
    c.runnable = rn; c.keep = kp;
    c.budget = b; c.now = n;
    return c;
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.cmd = sel < 22 ? mqs_pkg::CMD_ADD_TAIL : sel < 36 ? mqs_pkg::CMD_ADD_HEAD :
            sel < 58 ? mqs_pkg::CMD_SET_STATUS :
            sel < 80 ? mqs_pkg::CMD_YIELD : mqs_pkg::CMD_CLOCK_YIELD;
    c.task_id = mqs_pkg::TaskW'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 11) :
                                                              $urandom_range(0, 63));
    c.prio = mqs_pkg::LevelW'($urandom_range(0, 7));
    c.runnable = $urandom_range(0, 3) != 0;
    c.keep = $urandom_range(0, 3) == 0;
    sel = $urandom_range(0, 99);
    if (sel < 50) c.budget = clock_now + $urandom_range(0, 400);
    else if (sel < 60) c.budget = $urandom_range(0, 300);
    else if (sel < 70) c.budget = -$urandom_range(1, 300);
    else if (sel < 80) c.budget = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    else c.budget = $urandom;
    if ($urandom_range(0, 19) == 0) clock_now = mqs_pkg::NowW'($urandom);
    else clock_now = clock_now + mqs_pkg::NowW'($urandom_range(0, 150));
    c.now = clock_now;
    return c;
  endfunction

  task automatic cfg_write(logic [mqs_pkg::CfgIdxW-1:0] idx,
                           logic [mqs_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mqs_pkg::CFG_QUANTUM:      quantum_r = val;
      mqs_pkg::CFG_EXEMPT_LEVEL: exempt_r = val[mqs_pkg::LevelW-1:0];
      mqs_pkg::CFG_LOWEST_LEVEL: lowest_r = val[mqs_pkg::LevelW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || req_bus.valid || pick_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [mqs_pkg::CfgDataW-1:0] q_set[8];
    int ex_set[8], lo_set[8];
    req_bus.valid = 1'b0;
    req_bus.cmd = mqs_pkg::CMD_ADD_TAIL;
    req_bus.task_id = '0;
    req_bus.priority_req = '0;
    req_bus.runnable = 1'b0;
    req_bus.keep_budget = 1'b0;
    req_bus.budget = '0;
    req_bus.now = '0;
    rsp_bus.ready = 1'b0;
    shadow_reset();
    q_set = '{31'd100, 31'd1, 31'h7fff_ffff, 31'd37, 31'd5, 31'd250, 31'd1, 31'd64};
    ex_set = '{1, 0, 7, 3, 7, 0, 2, 5};
    lo_set = '{0, 7, 0, 2, 0, 5, 0, 1};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: empty yields, extremes, duplicate add, non-runnable drop.
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_CLOCK_YIELD, 0, 0, 0, 0, 0, 31'h7fff_ffff));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_TAIL, 0, 0, 0, 0, 32'h8000_0000, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_TAIL, 63, 7, 0, 0, 32'h7fff_ffff, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_HEAD, 5, 7, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_TAIL, 9, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_TAIL, 5, 7, 0, 1, 32'hffff_ffff, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_SET_STATUS, 0, 0, 1, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_SET_STATUS, 63, 0, 1, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_SET_STATUS, 9, 0, 1, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 31'd10));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_CLOCK_YIELD, 0, 0, 0, 0, 0, 31'd20));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 31'h7fff_ffff));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_SET_STATUS, 63, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_ADD_HEAD, 63, 7, 0, 1, 0, 0));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 31'd30));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_CLOCK_YIELD, 0, 0, 0, 0, 0, 31'd40));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 31'd50));
    cmd_backlog.push_back(mk(mqs_pkg::CMD_YIELD, 0, 0, 0, 0, 0, 31'd60));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(mqs_pkg::CFG_QUANTUM, q_set[ph]);
      cfg_write(mqs_pkg::CFG_EXEMPT_LEVEL, mqs_pkg::CfgDataW'(ex_set[ph]));
      cfg_write(mqs_pkg::CFG_LOWEST_LEVEL, mqs_pkg::CfgDataW'(lo_set[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int i = 0; i < 135; i++) cmd_backlog.push_back(random_cmd());
      drain();
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Driver: a new beat is presented once the previous one has been taken.
  always @(negedge clk) begin
    sched_cmd_t c;
    bit drive;
    if (!rst) begin
      drive = req_bus.valid && !req_took;
      if (!drive && cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        c = cmd_backlog.pop_front();
        req_bus.cmd <= c.cmd;
        req_bus.task_id <= c.task_id;
        req_bus.priority_req <= c.prio;
        req_bus.runnable <= c.runnable;
        req_bus.keep_budget <= c.keep;
        req_bus.budget <= c.budget;
        req_bus.now <= c.now;
        drive = 1'b1;
      end
      req_bus.valid <= drive;
      rsp_bus.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Monitor: predict on each accepted command, check each accepted result.
  always @(posedge clk) begin
    sched_cmd_t c;
    sched_pick_t e;
    req_took = 1'b0;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        req_took = 1'b1;
        c = mk(req_bus.cmd, req_bus.task_id, req_bus.priority_req, req_bus.runnable,
               req_bus.keep_budget, req_bus.budget, req_bus.now);
        pick_q.push_back(schedule(c));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pick_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = pick_q.pop_front();
          if (rsp_bus.dispatched !== e.dispatched || rsp_bus.run_task !== e.run_task ||
              rsp_bus.deadline !== e.deadline || rsp_bus.idle !== e.idle) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected disp=%0b task=%0d dl=%h idle=%0b,",
                       $realtime, e.dispatched, e.run_task, e.deadline, e.idle,
                       " got disp=%0b task=%0d dl=%h idle=%0b",
                       rsp_bus.dispatched, rsp_bus.run_task, rsp_bus.deadline, rsp_bus.idle);
          end
        end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
